FILE: rtl/core/ccw_pkg.sv
package ccw_pkg;

    // register indexes on the configuration channel
    localparam logic [1:0] REG_TEXT_ATTR      = 2'd0;
    localparam logic [1:0] REG_ERROR_COLOUR   = 2'd1;
    localparam logic [1:0] REG_INITIAL_ROW    = 2'd2;
    localparam logic [1:0] REG_INITIAL_COL    = 2'd3;

    localparam logic [7:0] TEXT_ATTR_RST      = 8'd7;
    localparam logic [7:0] ERROR_COLOUR_RST   = 8'd4;

    // result item kinds
    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    localparam int M_DATA_W = 32;

    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_CTRL_MAX  = 8'h1F;
    localparam logic [7:0] CHR_DEL       = 8'h7F;
    localparam logic [7:0] CHR_PRINT_MAX = 8'h7E;
    localparam logic [6:0] GLYPH_SPACE   = 7'h20;
    localparam logic [6:0] GLYPH_CARET   = 7'h5E;
    localparam logic [6:0] GLYPH_BSLASH  = 7'h5C;
    localparam logic [6:0] GLYPH_X       = 7'h78;
    localparam logic [7:0] CTRL_FLIP     = 8'h40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEWLINE,
        ST_CELL,
        ST_SCROLL
    } state_t;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_LOAD_ROW,
        CUR_LOAD_COL
    } cur_cmd_t;

    typedef enum logic [2:0] {
        BC_NEWLINE,
        BC_TAB,
        BC_CTRL,
        BC_PRINT,
        BC_HIGH
    } byte_class_t;

    typedef struct packed {
        logic wrap;      // column step would reach the screen width
        logic row_last;  // cursor sits on the bottom row
    } cur_status_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (b == CHR_NEWLINE) begin
            c = BC_NEWLINE;
        end else if (b == CHR_TAB) begin
            c = BC_TAB;
        end else if (b <= CHR_CTRL_MAX || b == CHR_DEL) begin
            c = BC_CTRL;
        end else if (b <= CHR_PRINT_MAX) begin
            c = BC_PRINT;
        end else begin
            c = BC_HIGH;
        end
        return c;
    endfunction

    function automatic logic [6:0] hex_glyph(input logic [3:0] n);
        logic [6:0] g;
        if (n < 4'd10) begin
            g = 7'h30 + 7'(n);
        end else begin
            g = 7'h37 + 7'(n);
        end
        return g;
    endfunction

endpackage

FILE: rtl/core/ccw_cursor.sv
module ccw_cursor import ccw_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cur_cmd_t                       cmd,
    input  logic [7:0]                     load_val,
    output logic [$clog2(SCREEN_ROWS)-1:0] row,
    output logic [$clog2(SCREEN_COLS)-1:0] col,
    output cur_status_t                    status
);

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS);

    logic [ROW_W-1:0] row_reg, row_next, row_step;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W:0]   col_inc;
    logic [4:0]       ld_row;
    logic [6:0]       ld_col;

    assign ld_row = load_val[4:0];
    assign ld_col = load_val[6:0];

    // shared step unit: one increment and compare per axis
    assign col_inc         = (COL_W+1)'(col_reg) + (COL_W+1)'(1);
    assign status.wrap     = (col_inc == (COL_W+1)'(SCREEN_COLS));
    assign status.row_last = (row_reg == ROW_W'(SCREEN_ROWS - 1));
    // bottom row stays put; the scroll item moves the screen instead
    assign row_step        = status.row_last ? row_reg : row_reg + ROW_W'(1);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (cmd)
            CUR_NONE: begin
            end
            CUR_ADVANCE: begin
                if (status.wrap) begin
                    col_next = '0;
                    row_next = row_step;
                end else begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            CUR_NEWLINE: begin
                col_next = '0;
                row_next = row_step;
            end
            CUR_LOAD_ROW: begin
                if (int'(ld_row) >= SCREEN_ROWS) begin
                    row_next = ROW_W'(SCREEN_ROWS - 1);
                end else begin
                    row_next = ROW_W'(ld_row);
                end
            end
            CUR_LOAD_COL: begin
                if (int'(ld_col) >= SCREEN_COLS) begin
                    col_next = COL_W'(SCREEN_COLS - 1);
                end else begin
                    col_next = COL_W'(ld_col);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign row = row_reg;
    assign col = col_reg;

endmodule

FILE: rtl/core/ccw_seq.sv
module ccw_seq import ccw_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80,
    parameter int TAB_SPACES  = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic [7:0]                     text_attr,
    input  logic [7:0]                     error_colour,
    input  logic [$clog2(SCREEN_ROWS)-1:0] cur_row,
    input  logic [$clog2(SCREEN_COLS)-1:0] cur_col,
    input  cur_status_t                    cur_status,
    output cur_cmd_t                       cur_cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DATA_W-1:0]            m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int MAX_CELLS = (TAB_SPACES > 4) ? TAB_SPACES : 4;
    localparam int IDX_W     = $clog2(MAX_CELLS + 1);

    state_t              state_reg, state_next;
    byte_class_t         class_reg;
    logic [7:0]          byte_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next, ncells;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg, m_last_reg;

    logic                accept, can_emit, emit, cnt_last, cell_scroll;
    logic                item_kind, item_last;
    logic [6:0]          glyph;
    logic [7:0]          attr;
    logic [M_DATA_W-1:0] item_data;

    assign accept      = s_tvalid && s_tready;
    assign can_emit    = !m_valid_reg || m_tready;
    assign cell_scroll = cur_status.wrap && cur_status.row_last;
    assign cnt_last    = (idx_reg == ncells - IDX_W'(1));

    always_comb begin
        unique case (class_reg)
            BC_NEWLINE: ncells = '0;
            BC_TAB:     ncells = IDX_W'(TAB_SPACES);
            BC_CTRL:    ncells = IDX_W'(2);
            BC_PRINT:   ncells = IDX_W'(1);
            BC_HIGH:    ncells = IDX_W'(4);
            default:    ncells = '0;
        endcase
    end

    always_comb begin
        glyph = '0;
        attr  = error_colour;
        unique case (class_reg)
            BC_NEWLINE: glyph = '0;
            BC_TAB: begin
                glyph = GLYPH_SPACE;
                attr  = text_attr;
            end
            BC_CTRL: begin
                if (idx_reg == '0) begin
                    glyph = GLYPH_CARET;
                end else begin
                    glyph = 7'(byte_reg ^ CTRL_FLIP);
                end
            end
            BC_PRINT: begin
                glyph = byte_reg[6:0];
                attr  = text_attr;
            end
            BC_HIGH: begin
                unique case (idx_reg[1:0])
                    2'd0: glyph = GLYPH_BSLASH;
                    2'd1: glyph = GLYPH_X;
                    2'd2: glyph = hex_glyph(byte_reg[7:4]);
                    2'd3: glyph = hex_glyph(byte_reg[3:0]);
                    default: glyph = '0;
                endcase
            end
            default: glyph = '0;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        cur_cmd   = CUR_NONE;
        emit      = 1'b0;
        item_kind = KIND_CELL;
        item_last = 1'b0;
        idx_next  = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                idx_next = '0;
            end
            ST_NEWLINE: begin
                cur_cmd = CUR_NEWLINE;
            end
            ST_CELL: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    cur_cmd   = CUR_ADVANCE;
                    item_last = cnt_last && !cell_scroll;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            ST_SCROLL: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    item_kind = KIND_SCROLL;
                    // idx already stepped past the cell that caused the scroll
                    item_last = (idx_reg == ncells);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (classify(s_tdata) == BC_NEWLINE) ? ST_NEWLINE : ST_CELL;
                end
            end
            ST_NEWLINE: begin
                state_next = cur_status.row_last ? ST_SCROLL : ST_IDLE;
            end
            ST_CELL: begin
                if (can_emit) begin
                    priority if (cell_scroll) begin
                        state_next = ST_SCROLL;
                    end else if (cnt_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CELL;
                    end
                end
            end
            ST_SCROLL: begin
                if (can_emit) begin
                    state_next = (idx_reg == ncells) ? ST_IDLE : ST_CELL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // tdata: cell_row, cell_col, glyph, attribute from bit 0 up
    always_comb begin
        if (item_kind == KIND_SCROLL) begin
            item_data = '0;
        end else begin
            item_data = M_DATA_W'({attr, glyph, 7'(cur_col), 5'(cur_row)});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg  <= s_tdata;
            class_reg <= classify(s_tdata);
        end
        if (emit) begin
            m_data_reg <= item_data;
            m_user_reg <= item_kind;
            m_last_reg <= item_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/core/text_console_char_writer_top.sv
// Text console character writer.
// s_ channel: one beat per input byte (s_tdata[7:0]). Each byte becomes a run of
// result beats on the m_ channel, m_tlast set on the final beat of the run; a
// newline that is not on the bottom row gives no beat at all.
// m_tuser = 0: cell write, m_tdata holds row, column, glyph and attribute.
// m_tuser = 1: scroll the screen up one line and clear the bottom row; m_tdata = 0.
// cfg channel: cfg_index selects text color, error color, cursor row or
// cursor column; always ready, one write per cycle. Row and column writes load
// the cursor directly from cfg_data[4:0] and cfg_data[6:0], clamped to the screen.
// Timing: a byte is taken in ST_IDLE, then the sequencer issues one result beat
// per cycle through the shared cursor step unit while the m_ side does not stall:
// 1 cell for a printable byte, 2 for a control escape, 4 for a hex escape,
// TAB_SPACES for a tab, plus one scroll beat for each scroll. A newline moves the
// cursor in ST_NEWLINE, then ST_SCROLL when it scrolls; s_tready is low meanwhile.
// m_tvalid rises once the first result beat of a byte reaches the output register.
// A stalled m_ side freezes the sequencer with the beat held in the output
// register; nothing is dropped.
// Reset puts the cursor at row 0, column 0 and the colors at 7 and 4.
module text_console_char_writer_top import ccw_pkg::*; #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int TAB_SPACES  = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // byte_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // cell_row[4:0], cell_col[11:5], glyph[18:12],
                                           // attribute[26:19], zero[31:27]
    output logic                m_tuser,   // kind
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    logic [7:0]                     text_attr_reg, error_colour_reg;
    logic [$clog2(SCREEN_ROWS)-1:0] cur_row;
    logic [$clog2(SCREEN_COLS)-1:0] cur_col;
    cur_status_t                    cur_status;
    cur_cmd_t                       seq_cmd, cur_cmd;
    logic                           cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg    <= TEXT_ATTR_RST;
            error_colour_reg <= ERROR_COLOUR_RST;
        end else if (cfg_wr) begin
            if (cfg_index == REG_TEXT_ATTR) begin
                text_attr_reg <= cfg_data;
            end
            if (cfg_index == REG_ERROR_COLOUR) begin
                error_colour_reg <= cfg_data;
            end
        end
    end

    // cursor loads must come only while the sequencer is idle; the block does not enforce this
    always_comb begin
        priority if (cfg_wr && cfg_index == REG_INITIAL_ROW) begin
            cur_cmd = CUR_LOAD_ROW;
        end else if (cfg_wr && cfg_index == REG_INITIAL_COL) begin
            cur_cmd = CUR_LOAD_COL;
        end else begin
            cur_cmd = seq_cmd;
        end
    end

    ccw_cursor #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_cursor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cur_cmd),
        .load_val (cfg_data),
        .row      (cur_row),
        .col      (cur_col),
        .status   (cur_status)
    );

    ccw_seq #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .TAB_SPACES  (TAB_SPACES)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .text_attr      (text_attr_reg),
        .error_colour   (error_colour_reg),
        .cur_row        (cur_row),
        .cur_col        (cur_col),
        .cur_status     (cur_status),
        .cur_cmd        (seq_cmd),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

FILE: rtl/core/ccw_checker.sv
module ccw_checker import ccw_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic                m_tuser,
    input logic                m_tlast
);

    // one byte at a time: the input side closes right after a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two cycles in a row");

    a_scroll_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("scroll beat carries cell data");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:27] == '0)
        else $error("tdata padding not zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

endmodule

bind text_console_char_writer_top ccw_checker u_ccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
